[hw/rtl/r2fft_pkg.sv]
// Shared types, constants and the twiddle table of the radix-2 FFT/IFFT block.
`timescale 1ns / 1ps
package r2fft_pkg;

  // Work memory and transform size
  localparam int MAX_LOG   = 6;
  localparam int MAX_PTS   = 1 << MAX_LOG;
  localparam int ADDR_BITS = MAX_LOG;
  localparam int WORK_BITS = 27;
  localparam int LOG_BITS  = 3;
  localparam int BF_BITS   = MAX_LOG - 1;

  // Twiddles: Q1.15 with one extra bit for exactly +1.0 and -1.0
  localparam int TW_FRAC = 15;
  localparam int TW_BITS = TW_FRAC + 2;
  localparam int PROD_BITS = TW_BITS + WORK_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int W_BITS    = SUM_BITS - TW_FRAC;

  // Register byte addresses
  localparam int APB_ADDR_BITS = 3;
  localparam logic [APB_ADDR_BITS-1:0] REG_SIZE_LOG2    = 3'd0;
  localparam logic [APB_ADDR_BITS-1:0] REG_INVERSE_MODE = 3'd4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WRQ,
    ST_OUT_RD,
    ST_OUT_PUT
  } state_t;

  typedef enum logic [1:0] {
    WR_SAMPLE,
    WR_SUM,
    WR_DIFF
  } wr_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic                 we;
    wr_sel_t              wsel;
    logic [ADDR_BITS-1:0] waddr;
    logic [ADDR_BITS-1:0] ra0;
    logic [ADDR_BITS-1:0] ra1;
    logic [BF_BITS-1:0]   tw_idx;
    logic                 mul_en;
    logic                 diff_en;
    logic                 out_load;
    logic                 out_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // cos(pi*i/32) for i in 0..16, scaled by 2^15 and rounded
  function automatic logic signed [TW_BITS-1:0] qcos(input logic [4:0] i);
    logic signed [TW_BITS-1:0] v;
    case (i)
      5'd0:    v = 17'sd32768;
      5'd1:    v = 17'sd32610;
      5'd2:    v = 17'sd32138;
      5'd3:    v = 17'sd31357;
      5'd4:    v = 17'sd30274;
      5'd5:    v = 17'sd28899;
      5'd6:    v = 17'sd27246;
      5'd7:    v = 17'sd25330;
      5'd8:    v = 17'sd23170;
      5'd9:    v = 17'sd20788;
      5'd10:   v = 17'sd18205;
      5'd11:   v = 17'sd15447;
      5'd12:   v = 17'sd12540;
      5'd13:   v = 17'sd9512;
      5'd14:   v = 17'sd6393;
      5'd15:   v = 17'sd3212;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  // cos(2*pi*m/64) for m in 0..31
  function automatic logic signed [TW_BITS-1:0] tw_cos(input logic [BF_BITS-1:0] m);
    logic signed [TW_BITS-1:0] v;
    if (m <= 5'd16) begin
      v = qcos(m);
    end else begin
      v = -qcos(5'(6'd32 - {1'b0, m}));
    end
    return v;
  endfunction

  // sin(2*pi*m/64) for m in 0..31
  function automatic logic signed [TW_BITS-1:0] tw_sin(input logic [BF_BITS-1:0] m);
    logic signed [TW_BITS-1:0] v;
    if (m <= 5'd16) begin
      v = qcos(5'(5'd16 - m));
    end else begin
      v = qcos(5'(m - 5'd16));
    end
    return v;
  endfunction

  // Bit reversal over the full address width
  function automatic logic [ADDR_BITS-1:0] bit_rev(input logic [ADDR_BITS-1:0] x);
    logic [ADDR_BITS-1:0] r;
    for (int i = 0; i < ADDR_BITS; i++) begin
      r[i] = x[ADDR_BITS-1-i];
    end
    return r;
  endfunction

endpackage

[hw/rtl/radix2_fft_ifft.sv]
// Top level of the radix-2 FFT/IFFT block: register port, controller and datapath.
//
//   Channel   Direction  Handshake            Payload
//   samples   in         in_valid / in_stall  sample_real, sample_imag
//   bins      out        out_valid/out_stall  result_real, result_imag, last_bin
//   config    in         APB write/read       size_log2 @0x0, inverse_mode @0x4
//
// Loading writes each sample to its bit-reversed address. Each butterfly steps
// through read, multiply, write upper and write lower on the single-write work
// memory. Readout reads each bin, then loads it into the output register once
// that is free. Synchronous reset clears control state, config registers and
// out_valid; no memory clearing.
// in_stall is high from the last sample of a frame until the last bin enters
// the output register.
`timescale 1ns / 1ps
module radix2_fft_ifft
  import r2fft_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_BITS-1:0]      paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_real,
  input  logic signed [SAMPLE_BITS-1:0] sample_imag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [WORK_BITS-1:0]   result_real,
  output logic signed [WORK_BITS-1:0]   result_imag,
  output logic                          last_bin
);

  logic [LOG_BITS-1:0] size_log2;
  logic                inverse_mode;
  logic [LOG_BITS-1:0] eff_log;
  logic                wr_en;
  logic                cnt_clear;
  dp_cmd_t             cmd;
  dp_stat_t            stat;

  // Register port
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign cnt_clear = wr_en && (paddr == REG_SIZE_LOG2);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2    <= 3'd6;
      inverse_mode <= 1'b0;
    end else if (wr_en) begin
      case (paddr)
        REG_SIZE_LOG2:    size_log2    <= pwdata[LOG_BITS-1:0];
        REG_INVERSE_MODE: inverse_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_SIZE_LOG2:    prdata = {29'd0, size_log2};
      REG_INVERSE_MODE: prdata = {31'd0, inverse_mode};
      default:          prdata = '0;
    endcase
  end

  // Length clamped to 2..64 points
  always_comb begin
    case (size_log2) inside
      3'd0:       eff_log = 3'd1;
      [3'd1:3'd6]: eff_log = size_log2;
      default:    eff_log = 3'd6;
    endcase
  end

  r2fft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .eff_log   (eff_log),
    .cnt_clear (cnt_clear),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  r2fft_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .eff_log      (eff_log),
    .inverse_mode (inverse_mode),
    .sample_real  (sample_real),
    .sample_imag  (sample_imag),
    .result_real  (result_real),
    .result_imag  (result_imag),
    .last_bin     (last_bin),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule

[hw/rtl/r2fft_ctrl.sv]
// Sequencer of the FFT/IFFT block: load, butterfly stages and bin readout.
`timescale 1ns / 1ps
module r2fft_ctrl
  import r2fft_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [LOG_BITS-1:0] eff_log,
  input  logic                cnt_clear,
  input  logic                in_valid,
  output logic                in_stall,
  input  dp_stat_t            stat,
  output dp_cmd_t             cmd
);

  state_t state, state_next;

  logic [ADDR_BITS:0]   load_count;
  logic [BF_BITS-1:0]   bf;
  logic [LOG_BITS-1:0]  stage;
  logic [ADDR_BITS-1:0] bin;

  logic                 in_take;
  logic [ADDR_BITS-1:0] n_m1;
  logic [ADDR_BITS-1:0] half_n_m1;
  logic [ADDR_BITS-1:0] half;
  logic [ADDR_BITS-1:0] kmask;
  logic [ADDR_BITS-1:0] bx;
  logic [ADDR_BITS-1:0] k;
  logic [ADDR_BITS-1:0] addr_p;
  logic [ADDR_BITS-1:0] addr_q;
  logic [ADDR_BITS-1:0] tw_full;
  logic [LOG_BITS-1:0]  tw_shift;
  logic                 load_last;
  logic                 bf_last;
  logic                 stage_last;
  logic                 bin_last;

  // Sizes and butterfly addressing
  assign n_m1      = ADDR_BITS'((7'd1 << eff_log) - 7'd1);
  assign half_n_m1 = ADDR_BITS'((7'd1 << (eff_log - 3'd1)) - 7'd1);
  assign half      = ADDR_BITS'(7'd1 << stage);
  assign kmask     = half - 6'd1;
  assign bx        = {1'b0, bf};
  assign k         = bx & kmask;
  assign addr_p    = ((bx & ~kmask) << 1) | k;
  assign addr_q    = addr_p | half;
  assign tw_shift  = LOG_BITS'(3'd5 - stage);
  assign tw_full   = k << tw_shift;

  assign in_take    = (state == ST_LOAD) && in_valid;
  assign load_last  = (load_count[ADDR_BITS-1:0] == n_m1);
  assign bf_last    = (bx == half_n_m1);
  assign stage_last = (stage == eff_log - 3'd1);
  assign bin_last   = (bin == n_m1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:    if (in_take && load_last) state_next = ST_BF_RD;
      ST_BF_RD:   state_next = ST_BF_MUL;
      ST_BF_MUL:  state_next = ST_BF_ADD;
      ST_BF_ADD:  state_next = ST_BF_WRQ;
      ST_BF_WRQ: begin
        if (bf_last && stage_last) state_next = ST_OUT_RD;
        else state_next = ST_BF_RD;
      end
      ST_OUT_RD:  state_next = ST_OUT_PUT;
      ST_OUT_PUT: begin
        if (stat.out_free) state_next = bin_last ? ST_LOAD : ST_OUT_RD;
      end
      default:    state_next = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    cmd.wsel     = WR_SAMPLE;
    cmd.ra0      = addr_p;
    cmd.ra1      = addr_q;
    cmd.tw_idx   = tw_full[BF_BITS-1:0];
    cmd.out_last = bin_last;
    in_stall     = 1'b1;
    case (state)
      ST_LOAD: begin
        in_stall  = 1'b0;
        cmd.we    = in_take;
        cmd.waddr = bit_rev(load_count[ADDR_BITS-1:0]) >> (3'd6 - eff_log);
      end
      ST_BF_MUL: cmd.mul_en = 1'b1;
      ST_BF_ADD: begin
        cmd.we      = 1'b1;
        cmd.wsel    = WR_SUM;
        cmd.waddr   = addr_p;
        cmd.diff_en = 1'b1;
      end
      ST_BF_WRQ: begin
        cmd.we    = 1'b1;
        cmd.wsel  = WR_DIFF;
        cmd.waddr = addr_q;
      end
      ST_OUT_RD:  cmd.ra0 = bin;
      ST_OUT_PUT: begin
        cmd.ra0      = bin;
        cmd.out_load = stat.out_free;
      end
      default: ;
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      bf         <= '0;
      stage      <= '0;
      bin        <= '0;
    end else begin
      state <= state_next;
      if (cnt_clear) begin
        load_count <= '0;
      end else if (in_take) begin
        load_count <= load_last ? '0 : load_count + 7'd1;
      end
      if (state == ST_BF_WRQ) begin
        if (bf_last) begin
          bf    <= '0;
          stage <= stage_last ? '0 : stage + 3'd1;
        end else begin
          bf <= bf + 5'd1;
        end
      end
      if (state == ST_OUT_PUT && stat.out_free) begin
        bin <= bin_last ? '0 : bin + 6'd1;
      end
    end
  end

endmodule

[hw/rtl/r2fft_dp.sv]
// Datapath of the FFT/IFFT block: work memory, butterfly unit and output register.
`timescale 1ns / 1ps
module r2fft_dp
  import r2fft_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dp_cmd_t                       cmd,
  output dp_stat_t                      stat,
  input  logic [LOG_BITS-1:0]           eff_log,
  input  logic                          inverse_mode,
  input  logic signed [SAMPLE_BITS-1:0] sample_real,
  input  logic signed [SAMPLE_BITS-1:0] sample_imag,
  output logic signed [WORK_BITS-1:0]   result_real,
  output logic signed [WORK_BITS-1:0]   result_imag,
  output logic                          last_bin,
  output logic                          out_valid,
  input  logic                          out_stall
);

  localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) <<< (TW_FRAC - 1);

  logic signed [WORK_BITS-1:0] mem_re [MAX_PTS];
  logic signed [WORK_BITS-1:0] mem_im [MAX_PTS];

  logic signed [WORK_BITS-1:0] a_re, a_im, b_re, b_im;
  logic signed [WORK_BITS-1:0] wd_re, wd_im;
  logic signed [WORK_BITS-1:0] diff_re, diff_im;
  logic signed [TW_BITS-1:0]   tc, ts, td;
  logic signed [PROD_BITS-1:0] p_cbr, p_dbi, p_cbi, p_dbr;
  logic signed [SUM_BITS-1:0]  s_re, s_im;
  logic signed [W_BITS-1:0]    w_re, w_im;
  logic signed [WORK_BITS-1:0] sum_re, sum_im, dif_re, dif_im;
  logic signed [WORK_BITS:0]   rnd, sc_re, sc_im;
  logic signed [WORK_BITS-1:0] o_re, o_im;

  // Work memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem_re[cmd.waddr] <= wd_re;
      mem_im[cmd.waddr] <= wd_im;
    end
    a_re <= mem_re[cmd.ra0];
    a_im <= mem_im[cmd.ra0];
    b_re <= mem_re[cmd.ra1];
    b_im <= mem_im[cmd.ra1];
  end

  always_comb begin
    case (cmd.wsel)
      WR_SUM: begin
        wd_re = sum_re;
        wd_im = sum_im;
      end
      WR_DIFF: begin
        wd_re = diff_re;
        wd_im = diff_im;
      end
      default: begin
        wd_re = WORK_BITS'(sample_real);
        wd_im = WORK_BITS'(sample_imag);
      end
    endcase
  end

  // Twiddle, sine conjugated for the inverse
  assign tc = tw_cos(cmd.tw_idx);
  assign ts = tw_sin(cmd.tw_idx);
  assign td = inverse_mode ? -ts : ts;

  // Products
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_cbr <= tc * b_re;
      p_dbi <= td * b_im;
      p_cbi <= tc * b_im;
      p_dbr <= td * b_re;
    end
  end

  // Round half up, then sum and difference wrapped to the work width
  assign s_re   = SUM_BITS'(p_cbr) + SUM_BITS'(p_dbi) + ROUND_HALF;
  assign s_im   = SUM_BITS'(p_cbi) - SUM_BITS'(p_dbr) + ROUND_HALF;
  assign w_re   = W_BITS'(s_re >>> TW_FRAC);
  assign w_im   = W_BITS'(s_im >>> TW_FRAC);
  assign sum_re = a_re + w_re[WORK_BITS-1:0];
  assign sum_im = a_im + w_im[WORK_BITS-1:0];
  assign dif_re = a_re - w_re[WORK_BITS-1:0];
  assign dif_im = a_im - w_im[WORK_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      diff_re <= dif_re;
      diff_im <= dif_im;
    end
  end

  // Inverse scaling by 1/N with rounding
  assign rnd   = (WORK_BITS+1)'(1) <<< (eff_log - 3'd1);
  assign sc_re = ((WORK_BITS+1)'(a_re) + rnd) >>> eff_log;
  assign sc_im = ((WORK_BITS+1)'(a_im) + rnd) >>> eff_log;
  assign o_re  = inverse_mode ? sc_re[WORK_BITS-1:0] : a_re;
  assign o_im  = inverse_mode ? sc_im[WORK_BITS-1:0] : a_im;

  // Output register
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_real <= o_re;
      result_imag <= o_im;
      last_bin    <= cmd.out_last;
    end
  end

endmodule
